### rtl/core/ditp_pkg.sv
// Package with the types, character codes and key tables of the display-info text parser.
`timescale 1ns / 1ps

package ditp_pkg;

  // Width of the internal value registers; values saturate at its maximum.
  localparam int VALUE_BITS = 16;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  // Width of each value field in a result item.
  localparam int OUT_BITS = 16;

  // Width of the text character field.
  localparam int CHAR_BITS = 8;

  // Character codes.
  localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_H     = 8'h48;

  // Key lengths and the key selector.
  localparam logic [2:0] LEN_WIDTH  = 3'd5;
  localparam logic [2:0] LEN_HEIGHT = 3'd6;
  localparam logic       KEY_WIDTH  = 1'b0;
  localparam logic       KEY_HEIGHT = 1'b1;

  // Phases of the line parser.
  typedef enum logic [2:0] {
    PH_LINE_WS,
    PH_MATCH,
    PH_AFTER_KEY,
    PH_AFTER_COL,
    PH_DIGITS,
    PH_SKIP_LINE
  } ditp_phase_t;

  // Values carried by one result item.
  typedef struct packed {
    logic [OUT_BITS-1:0] height_value;
    logic [OUT_BITS-1:0] width_value;
  } ditp_result_t;

  // Expected character of a key at a given position.
  function automatic logic [CHAR_BITS-1:0] key_char(input logic key, input logic [2:0] pos);
    logic [CHAR_BITS-1:0] ch;
    ch = CH_NUL;
    if (key == KEY_WIDTH) begin
      unique case (pos)
        3'd0:    ch = 8'h57; // W
        3'd1:    ch = 8'h49; // I
        3'd2:    ch = 8'h44; // D
        3'd3:    ch = 8'h54; // T
        3'd4:    ch = 8'h48; // H
        default: ch = CH_NUL;
      endcase
    end else begin
      unique case (pos)
        3'd0:    ch = 8'h48; // H
        3'd1:    ch = 8'h45; // E
        3'd2:    ch = 8'h49; // I
        3'd3:    ch = 8'h47; // G
        3'd4:    ch = 8'h48; // H
        3'd5:    ch = 8'h54; // T
        default: ch = CH_NUL;
      endcase
    end
    return ch;
  endfunction

  // Blank, tab or newline.
  function automatic logic is_ws(input logic [CHAR_BITS-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
  endfunction

  // Decimal digit.
  function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

### rtl/core/ditp_parser.sv
// Line parser: phase state, key matching, digit accumulation and the stored values.
`timescale 1ns / 1ps

module ditp_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [ditp_pkg::CHAR_BITS-1:0] text_byte,
  input  logic                           end_of_text,
  output logic                           result_valid,
  output ditp_pkg::ditp_result_t         result
);
  import ditp_pkg::*;

  localparam int WIDE_BITS = VALUE_BITS + 4;

  ditp_phase_t           phase, phase_next;
  logic [2:0]            match_pos, match_pos_next;
  logic                  cur_key, cur_key_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic [VALUE_BITS-1:0] stored_width, stored_width_next;
  logic [VALUE_BITS-1:0] stored_height, stored_height_next;

  logic                  text_end;
  logic [3:0]            digit;
  logic [WIDE_BITS-1:0]  acc_wide;
  logic [VALUE_BITS-1:0] acc_sat;
  logic                  m_key;
  logic [2:0]            m_pos;
  logic [2:0]            m_len;
  logic [2:0]            m_pos_inc;
  logic [CHAR_BITS-1:0]  digit_diff;

  assign text_end   = (text_byte == CH_NUL) || end_of_text;
  assign digit_diff = text_byte - CH_ZERO;
  assign digit      = digit_diff[3:0];

  // Multiply by ten as two shifts, add the digit, then saturate.
  assign acc_wide = (WIDE_BITS'(acc) << 3) + (WIDE_BITS'(acc) << 1) + WIDE_BITS'(digit);
  assign acc_sat  = (acc_wide > WIDE_BITS'(VALUE_MAX)) ? VALUE_MAX : acc_wide[VALUE_BITS-1:0];

  // Key and position that the current byte is matched against.
  always_comb begin
    m_key = (phase == PH_MATCH) ? cur_key : KEY_WIDTH;
    m_len = (m_key == KEY_HEIGHT) ? LEN_HEIGHT : LEN_WIDTH;
    if ((phase != PH_MATCH) || (match_pos >= m_len)) begin
      m_pos = 3'd0;
    end else begin
      m_pos = match_pos;
    end
    m_pos_inc = m_pos + 3'd1;
  end

  // Next-state logic for one parsed byte.
  always_comb begin
    phase_next         = phase;
    match_pos_next     = match_pos;
    cur_key_next       = cur_key;
    acc_next           = acc;
    stored_width_next  = stored_width;
    stored_height_next = stored_height;

    if (text_byte != CH_NUL) begin
      unique case (phase)
        PH_LINE_WS, PH_MATCH: begin
          if ((phase == PH_LINE_WS) && is_ws(text_byte)) begin
            phase_next = PH_LINE_WS;
          end else if (text_byte == key_char(m_key, m_pos)) begin
            cur_key_next = m_key;
            if (m_pos_inc == m_len) begin
              phase_next     = PH_AFTER_KEY;
              match_pos_next = 3'd0;
            end else begin
              phase_next     = PH_MATCH;
              match_pos_next = m_pos_inc;
            end
          end else if (m_key == KEY_WIDTH) begin
            // A failed WIDTH match retries the byte as the start of HEIGHT.
            cur_key_next = KEY_HEIGHT;
            if (text_byte == CH_H) begin
              phase_next     = PH_MATCH;
              match_pos_next = 3'd1;
            end else begin
              match_pos_next = 3'd0;
              phase_next     = (text_byte == CH_LF) ? PH_LINE_WS : PH_SKIP_LINE;
            end
          end else begin
            match_pos_next = 3'd0;
            phase_next     = (text_byte == CH_LF) ? PH_LINE_WS : PH_SKIP_LINE;
          end
        end
        PH_AFTER_KEY: begin
          if (is_ws(text_byte)) begin
            phase_next = PH_AFTER_KEY;
          end else if (text_byte == CH_COLON) begin
            phase_next = PH_AFTER_COL;
            acc_next   = '0;
            if (cur_key == KEY_HEIGHT) stored_height_next = '0;
            else                       stored_width_next  = '0;
          end else begin
            phase_next = (text_byte == CH_LF) ? PH_LINE_WS : PH_SKIP_LINE;
          end
        end
        PH_AFTER_COL: begin
          if (is_ws(text_byte)) begin
            phase_next = PH_AFTER_COL;
          end else if (is_digit(text_byte)) begin
            phase_next = PH_DIGITS;
            acc_next   = VALUE_BITS'(digit);
            if (cur_key == KEY_HEIGHT) stored_height_next = VALUE_BITS'(digit);
            else                       stored_width_next  = VALUE_BITS'(digit);
          end else begin
            phase_next = (text_byte == CH_LF) ? PH_LINE_WS : PH_SKIP_LINE;
          end
        end
        PH_DIGITS: begin
          if (is_digit(text_byte)) begin
            acc_next = acc_sat;
            if (cur_key == KEY_HEIGHT) stored_height_next = acc_sat;
            else                       stored_width_next  = acc_sat;
          end else begin
            phase_next = (text_byte == CH_LF) ? PH_LINE_WS : PH_SKIP_LINE;
          end
        end
        default: begin
          phase_next = (text_byte == CH_LF) ? PH_LINE_WS : PH_SKIP_LINE;
        end
      endcase
    end
  end

  // Result outputs: the stored values after this byte, at end of text.
  always_comb begin
    result_valid        = step && text_end;
    result.width_value  = OUT_BITS'(stored_width_next);
    result.height_value = OUT_BITS'(stored_height_next);
  end

  // State registers; end of text returns everything to the reset values.
  always_ff @(posedge clk) begin
    if (rst || (step && text_end)) begin
      phase         <= PH_LINE_WS;
      match_pos     <= 3'd0;
      cur_key       <= KEY_WIDTH;
      acc           <= '0;
      stored_width  <= '0;
      stored_height <= '0;
    end else if (step) begin
      phase         <= phase_next;
      match_pos     <= match_pos_next;
      cur_key       <= cur_key_next;
      acc           <= acc_next;
      stored_width  <= stored_width_next;
      stored_height <= stored_height_next;
    end
  end

endmodule

### rtl/core/ditp_result_reg.sv
// Output register that holds one result item until the downstream side takes it.
`timescale 1ns / 1ps

module ditp_result_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  ditp_pkg::ditp_result_t load_data,
  output logic                   busy,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata   // width_value [15:0], height_value [31:16]
);
  import ditp_pkg::*;

  logic         out_valid, out_valid_next;
  ditp_result_t out_data;

  // The register is free when empty or when its item leaves this cycle.
  assign busy = out_valid && !m_tready;

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_data.height_value, out_data.width_value};

endmodule

### rtl/core/display_info_text_parser_core.sv
// Top level of the display-info text parser: input register, line parser and result register.
//
//  Channel | Dir | Payload                                   | Sideband
//  s_*     | in  | tdata[7:0] = text_byte                    | tlast = end_of_text
//  m_*     | out | tdata[15:0] = width_value, [31:16] = height | none
//
// Each item is held in the input register; the parser updates its state as the item
// leaves that register, so one item is taken every cycle while no end-of-text item is held.
// A result item is written into the output register at the same edge at which its item
// leaves the input register. Stalls on the output only hold the input side when an item
// that ends a text finds the output register still full. Reset is synchronous and clears
// all parser state.
`timescale 1ns / 1ps

module display_info_text_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte [7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // width_value [15:0], height_value [31:16]
);
  import ditp_pkg::*;

  logic                 in_full;
  logic [CHAR_BITS-1:0] in_byte;
  logic                 in_last;
  logic                 in_ends_text;
  logic                 out_busy;
  logic                 step;
  logic                 res_valid;
  ditp_result_t         res;

  // An item moves on unless it ends the text and the output is still occupied.
  assign in_ends_text = (in_byte == CH_NUL) || in_last;
  assign step         = in_full && !(in_ends_text && out_busy);
  assign s_tready     = !in_full || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  ditp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .text_byte    (in_byte),
    .end_of_text  (in_last),
    .result_valid (res_valid),
    .result       (res)
  );

  ditp_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_data (res),
    .busy      (out_busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
